FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset
`define FA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define FA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/falloc_pkg.sv
// Shared constants, codes and types of the free-list allocator.
// No dependencies.
package falloc_pkg;

    localparam int AW      = 16;              // address and length width
    localparam int FN      = 16;              // free chunk table depth
    localparam int BN      = 16;              // used block table depth
    localparam int FIW     = $clog2(FN);
    localparam int BIW     = $clog2(BN);
    localparam int CW      = $clog2(FN + 1);  // counter width, holds FN itself
    localparam int UCW     = $clog2(BN + 1);
    localparam int PAW     = 3;               // APB byte address width
    localparam int DW      = 32;              // APB data width

    localparam logic [AW-1:0] POOL_RST = 16'hFFFF;

    // opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // fit policies (code 3 behaves as first fit)
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_POOL   = 1'b1;

    typedef struct packed {
        logic [AW:0] sum;
        logic [AW:0] diff;   // diff[AW] set when a < b
        logic        eq;
    } t_alu_res;

endpackage

FILE: rtl/falloc_if.sv
// Request and response channel interfaces of the allocator.
// Depends on falloc_pkg.
interface falloc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [falloc_pkg::AW-1:0] request_size;
    logic [falloc_pkg::AW-1:0] block_address;

    modport source (output valid, opcode, request_size, block_address, input ready);
    modport sink   (input valid, opcode, request_size, block_address, output ready);
endinterface

interface falloc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [falloc_pkg::AW-1:0] granted_address;
    logic [falloc_pkg::AW-1:0] available_bytes;

    modport source (output valid, status, granted_address, available_bytes, input ready);
    modport sink   (input valid, status, granted_address, available_bytes, output ready);
endinterface

FILE: rtl/falloc_alu.sv
// Shared add / subtract / compare unit used by the allocator sequencer.
// Depends on falloc_pkg.
module falloc_alu (
    input  logic [falloc_pkg::AW-1:0] i_a,
    input  logic [falloc_pkg::AW-1:0] i_b,
    output falloc_pkg::t_alu_res      o_res
);
    always_comb begin
        o_res.sum  = {1'b0, i_a} + {1'b0, i_b};
        o_res.diff = {1'b0, i_a} - {1'b0, i_b};
        o_res.eq   = (i_a == i_b);
    end
endmodule

FILE: rtl/fit_policy_free_list_allocator_unit.sv
// Fit-policy free-list pool allocator, top level.
// Depends on falloc_pkg, falloc_if, falloc_alu and assert_macros.svh.
//
// Usage:
//  - i_req carries one item: opcode (0 allocate, 1 release), request_size,
//    block_address. It is taken when valid and ready are both high.
//  - o_rsp returns one item per request: status, granted_address and the
//    free byte total after the operation.
//  - APB port: register 0 fit_policy at 0x0, register 1 pool_size at 0x4.
//    Writing pool_size empties the used table; nonzero leaves one free chunk.
//    Write only while the block is idle.
// Operation (steps from acceptance until the response is valid):
//  - Table arithmetic uses one shared adder/comparator under a sequencer.
//  - Allocate: scan the free table for a fit, under best or worst fit also
//    compare each further fitting entry with the pick, then carve the chunk
//    or shift the table; a zero size is refused without a scan.
//  - Release: look up the block, find its position in the free table, check
//    both neighbors, insert or merge with a free-table shift where needed,
//    then shift the used table; an unknown block ends after the lookup.
//  - i_req.ready is high only while the sequencer is idle: one item at a
//    time, the next taken at best in the cycle after the response is loaded.
//  - The response sits in an output register; the next item is accepted
//    while it waits. A finished item holds in the last step until the
//    output register is free.
// Reset: synchronous active-low; policy first fit, pool 65535 bytes.
`include "assert_macros.svh"

module fit_policy_free_list_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    falloc_req_if.sink                     i_req,
    falloc_rsp_if.source                   o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [falloc_pkg::PAW-1:0]     paddr,
    input  logic [falloc_pkg::DW-1:0]      pwdata,
    output logic [falloc_pkg::DW-1:0]      prdata,
    output logic                           pready
);
    localparam int AW  = falloc_pkg::AW;
    localparam int FIW = falloc_pkg::FIW;
    localparam int BIW = falloc_pkg::BIW;
    localparam int CW  = falloc_pkg::CW;
    localparam int UCW = falloc_pkg::UCW;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ASCAN  = 5'd1;   // scan free table for a fit
    localparam logic [4:0] S_ACHK   = 5'd2;   // record block, exact fit?
    localparam logic [4:0] S_ACARVE = 5'd3;   // move chunk start up
    localparam logic [4:0] S_ALEN   = 5'd4;   // shrink chunk length
    localparam logic [4:0] S_FSHDN  = 5'd5;   // remove a free entry
    localparam logic [4:0] S_AAVL   = 5'd6;   // free total minus size
    localparam logic [4:0] S_USCAN  = 5'd7;   // look up block to release
    localparam logic [4:0] S_FPOS   = 5'd8;   // insertion position
    localparam logic [4:0] S_PREV   = 5'd9;   // lower neighbor touches?
    localparam logic [4:0] S_NEXT   = 5'd10;  // upper neighbor touches?
    localparam logic [4:0] S_DEC    = 5'd11;
    localparam logic [4:0] S_MB1    = 5'd12;  // merge both: add block
    localparam logic [4:0] S_MB2    = 5'd13;  // merge both: add upper
    localparam logic [4:0] S_MP     = 5'd14;  // merge into lower
    localparam logic [4:0] S_MN     = 5'd15;  // merge into upper
    localparam logic [4:0] S_FSHUP  = 5'd16;  // open a slot and insert
    localparam logic [4:0] S_USH    = 5'd17;  // remove used entry
    localparam logic [4:0] S_RAVL   = 5'd18;  // free total plus block
    localparam logic [4:0] S_FIN    = 5'd19;  // hand result to output reg

    logic [4:0]     r_state;

    // tables
    logic [AW-1:0]  r_fs [falloc_pkg::FN];
    logic [AW-1:0]  r_fl [falloc_pkg::FN];
    logic [AW-1:0]  r_us [falloc_pkg::BN];
    logic [AW-1:0]  r_ul [falloc_pkg::BN];
    logic [CW-1:0]  r_fcnt;
    logic [UCW-1:0] r_ucnt;

    // configuration and running total
    logic [1:0]     r_policy;
    logic [AW-1:0]  r_pool;
    logic [AW-1:0]  r_avail;

    // per-item working registers
    logic           r_op;
    logic [AW-1:0]  r_size;
    logic [AW-1:0]  r_addr;
    logic [CW-1:0]  r_idx;
    logic [FIW-1:0] r_pick;
    logic [AW-1:0]  r_plen;
    logic           r_found;
    logic           r_ph;
    logic [CW-1:0]  r_pos;
    logic [AW-1:0]  r_blen;
    logic [AW-1:0]  r_nlen;
    logic [BIW-1:0] r_uidx;
    logic           r_ptouch;
    logic           r_ntouch;
    logic [1:0]     r_status;
    logic [AW-1:0]  r_grant;

    // output register
    logic           r_ovalid;
    logic [1:0]     r_ostat;
    logic [AW-1:0]  r_ogrant;
    logic [AW-1:0]  r_oavail;

    logic [CW-1:0]  c_idx_p1;
    logic [CW-1:0]  c_idx_m1;
    logic [CW-1:0]  c_pos_m1;
    logic [FIW-1:0] c_frd;
    logic [BIW-1:0] c_urd;
    logic [AW-1:0]  c_frd_s;
    logic [AW-1:0]  c_frd_l;
    logic [AW-1:0]  c_urd_s;
    logic [AW-1:0]  c_urd_l;
    logic [AW-1:0]  c_alu_a;
    logic [AW-1:0]  c_alu_b;
    falloc_pkg::t_alu_res c_alu;
    logic           c_req_acc;
    logic           c_cfg_wr;
    logic           c_fit_multi;

    assign c_idx_p1 = r_idx + CW'(1);
    assign c_idx_m1 = r_idx - CW'(1);
    assign c_pos_m1 = r_pos - CW'(1);
    assign c_fit_multi = (r_policy == falloc_pkg::FIT_BEST) ||
                         (r_policy == falloc_pkg::FIT_WORST);

    // one read port per table, address chosen by state
    always_comb begin
        case (r_state)
            S_ACHK, S_ACARVE:              c_frd = r_pick;
            S_FSHDN:                       c_frd = c_idx_p1[FIW-1:0];
            S_PREV, S_MB1, S_MB2, S_MP:    c_frd = c_pos_m1[FIW-1:0];
            S_NEXT, S_MN:                  c_frd = r_pos[FIW-1:0];
            S_FSHUP:                       c_frd = c_idx_m1[FIW-1:0];
            default:                       c_frd = r_idx[FIW-1:0];
        endcase
    end

    assign c_urd   = (r_state == S_USH) ? c_idx_p1[BIW-1:0] : r_idx[BIW-1:0];
    assign c_frd_s = r_fs[c_frd];
    assign c_frd_l = r_fl[c_frd];
    assign c_urd_s = r_us[c_urd];
    assign c_urd_l = r_ul[c_urd];

    // operand selection for the shared unit
    always_comb begin
        case (r_state)
            S_ASCAN: begin
                c_alu_a = c_frd_l;
                c_alu_b = r_ph ? r_plen : r_size;
            end
            S_ACHK, S_ALEN: begin
                c_alu_a = r_plen;
                c_alu_b = r_size;
            end
            S_ACARVE: begin
                c_alu_a = c_frd_s;
                c_alu_b = r_size;
            end
            S_AAVL: begin
                c_alu_a = r_avail;
                c_alu_b = r_size;
            end
            S_USCAN: begin
                c_alu_a = c_urd_s;
                c_alu_b = r_addr;
            end
            S_FPOS: begin
                c_alu_a = c_frd_s;
                c_alu_b = r_addr;
            end
            S_PREV: begin
                c_alu_a = c_frd_s;
                c_alu_b = c_frd_l;
            end
            S_NEXT: begin
                c_alu_a = r_addr;
                c_alu_b = r_blen;
            end
            S_MB1, S_MP: begin
                c_alu_a = c_frd_l;
                c_alu_b = r_blen;
            end
            S_MB2: begin
                c_alu_a = c_frd_l;
                c_alu_b = r_nlen;
            end
            S_MN: begin
                c_alu_a = r_blen;
                c_alu_b = r_nlen;
            end
            S_RAVL: begin
                c_alu_a = r_avail;
                c_alu_b = r_blen;
            end
            default: begin
                c_alu_a = '0;
                c_alu_b = '0;
            end
        endcase
    end

    falloc_alu u_alu (
        .i_a   (c_alu_a),
        .i_b   (c_alu_b),
        .o_res (c_alu)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign c_req_acc   = i_req.valid && i_req.ready;
    assign c_cfg_wr    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_policy <= falloc_pkg::FIT_FIRST;
            r_pool   <= falloc_pkg::POOL_RST;
            r_avail  <= falloc_pkg::POOL_RST;
            r_fs[0]  <= '0;
            r_fl[0]  <= falloc_pkg::POOL_RST;
            r_fcnt   <= CW'(1);
            r_ucnt   <= '0;
        end else begin
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (c_req_acc) begin
                        r_op     <= i_req.opcode;
                        r_size   <= i_req.request_size;
                        r_addr   <= i_req.block_address;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_ph     <= 1'b0;
                        r_ptouch <= 1'b0;
                        r_ntouch <= 1'b0;
                        r_grant  <= '0;
                        if (i_req.opcode == falloc_pkg::OP_RELEASE) begin
                            r_state <= S_USCAN;
                        end else if (i_req.request_size == '0) begin
                            r_status <= falloc_pkg::ST_NOFIT;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_ASCAN;
                        end
                    end
                end

                S_ASCAN: begin
                    if (r_idx == r_fcnt) begin
                        r_state <= S_ACHK;
                    end else if (!r_ph) begin
                        if (!c_alu.diff[AW]) begin
                            if (!r_found) begin
                                r_pick  <= r_idx[FIW-1:0];
                                r_plen  <= c_frd_l;
                                r_found <= 1'b1;
                                if (c_fit_multi) begin
                                    r_idx <= c_idx_p1;
                                end else begin
                                    r_state <= S_ACHK;
                                end
                            end else begin
                                r_ph <= 1'b1;
                            end
                        end else begin
                            r_idx <= c_idx_p1;
                        end
                    end else begin
                        // fitting chunk vs current pick; ties keep the lower one
                        r_ph  <= 1'b0;
                        r_idx <= c_idx_p1;
                        if ((r_policy == falloc_pkg::FIT_BEST && c_alu.diff[AW]) ||
                            (r_policy == falloc_pkg::FIT_WORST && !c_alu.diff[AW] &&
                             !c_alu.eq)) begin
                            r_pick <= r_idx[FIW-1:0];
                            r_plen <= c_frd_l;
                        end
                    end
                end

                S_ACHK: begin
                    if (!r_found) begin
                        r_status <= falloc_pkg::ST_NOFIT;
                        r_state  <= S_FIN;
                    end else if (r_ucnt == UCW'(falloc_pkg::BN)) begin
                        r_status <= falloc_pkg::ST_FULL;
                        r_state  <= S_FIN;
                    end else begin
                        r_us[r_ucnt[BIW-1:0]] <= c_frd_s;
                        r_ul[r_ucnt[BIW-1:0]] <= r_size;
                        r_ucnt  <= r_ucnt + UCW'(1);
                        r_grant <= c_frd_s;
                        if (c_alu.eq) begin
                            r_idx   <= CW'(r_pick);
                            r_state <= S_FSHDN;
                        end else begin
                            r_state <= S_ACARVE;
                        end
                    end
                end

                S_ACARVE: begin
                    r_fs[r_pick] <= c_alu.sum[AW-1:0];
                    r_state      <= S_ALEN;
                end

                S_ALEN: begin
                    r_fl[r_pick] <= c_alu.diff[AW-1:0];
                    r_state      <= S_AAVL;
                end

                S_FSHDN: begin
                    if (c_idx_p1 < r_fcnt) begin
                        r_fs[r_idx[FIW-1:0]] <= c_frd_s;
                        r_fl[r_idx[FIW-1:0]] <= c_frd_l;
                        r_idx <= c_idx_p1;
                    end else begin
                        r_fcnt <= r_fcnt - CW'(1);
                        if (r_op == falloc_pkg::OP_ALLOC) begin
                            r_state <= S_AAVL;
                        end else begin
                            r_idx   <= CW'(r_uidx);
                            r_state <= S_USH;
                        end
                    end
                end

                S_AAVL: begin
                    r_avail  <= c_alu.diff[AW-1:0];
                    r_status <= falloc_pkg::ST_OK;
                    r_state  <= S_FIN;
                end

                S_USCAN: begin
                    if (r_idx == CW'(r_ucnt)) begin
                        r_status <= falloc_pkg::ST_UNKNOWN;
                        r_state  <= S_FIN;
                    end else if (c_alu.eq) begin
                        r_uidx  <= r_idx[BIW-1:0];
                        r_blen  <= c_urd_l;
                        r_idx   <= '0;
                        r_state <= S_FPOS;
                    end else begin
                        r_idx <= c_idx_p1;
                    end
                end

                S_FPOS: begin
                    if (r_idx == r_fcnt || !c_alu.diff[AW]) begin
                        r_pos   <= r_idx;
                        r_state <= S_PREV;
                    end else begin
                        r_idx <= c_idx_p1;
                    end
                end

                S_PREV: begin
                    if (r_pos != '0) begin
                        r_ptouch <= (c_alu.sum == {1'b0, r_addr});
                    end
                    r_state <= S_NEXT;
                end

                S_NEXT: begin
                    if (r_pos != r_fcnt) begin
                        r_ntouch <= (c_alu.sum == {1'b0, c_frd_s});
                        r_nlen   <= c_frd_l;
                    end
                    r_state <= S_DEC;
                end

                S_DEC: begin
                    if (r_ptouch && r_ntouch) begin
                        r_state <= S_MB1;
                    end else if (r_ptouch) begin
                        r_state <= S_MP;
                    end else if (r_ntouch) begin
                        r_state <= S_MN;
                    end else if (r_fcnt == CW'(falloc_pkg::FN)) begin
                        r_status <= falloc_pkg::ST_FULL;
                        r_state  <= S_FIN;
                    end else begin
                        r_idx   <= r_fcnt;
                        r_state <= S_FSHUP;
                    end
                end

                S_MB1: begin
                    r_fl[c_pos_m1[FIW-1:0]] <= c_alu.sum[AW-1:0];
                    r_state <= S_MB2;
                end

                S_MB2: begin
                    // lower chunk now spans the upper one; drop the upper
                    r_fl[c_pos_m1[FIW-1:0]] <= c_alu.sum[AW-1:0];
                    r_idx   <= r_pos;
                    r_state <= S_FSHDN;
                end

                S_MP: begin
                    r_fl[c_pos_m1[FIW-1:0]] <= c_alu.sum[AW-1:0];
                    r_idx   <= CW'(r_uidx);
                    r_state <= S_USH;
                end

                S_MN: begin
                    r_fs[r_pos[FIW-1:0]] <= r_addr;
                    r_fl[r_pos[FIW-1:0]] <= c_alu.sum[AW-1:0];
                    r_idx   <= CW'(r_uidx);
                    r_state <= S_USH;
                end

                S_FSHUP: begin
                    if (r_idx != r_pos) begin
                        r_fs[r_idx[FIW-1:0]] <= c_frd_s;
                        r_fl[r_idx[FIW-1:0]] <= c_frd_l;
                        r_idx <= c_idx_m1;
                    end else begin
                        r_fs[r_pos[FIW-1:0]] <= r_addr;
                        r_fl[r_pos[FIW-1:0]] <= r_blen;
                        r_fcnt  <= r_fcnt + CW'(1);
                        r_idx   <= CW'(r_uidx);
                        r_state <= S_USH;
                    end
                end

                S_USH: begin
                    if (c_idx_p1 < CW'(r_ucnt)) begin
                        r_us[r_idx[BIW-1:0]] <= c_urd_s;
                        r_ul[r_idx[BIW-1:0]] <= c_urd_l;
                        r_idx <= c_idx_p1;
                    end else begin
                        r_ucnt  <= r_ucnt - UCW'(1);
                        r_state <= S_RAVL;
                    end
                end

                S_RAVL: begin
                    r_avail  <= c_alu.sum[AW-1:0];
                    r_status <= falloc_pkg::ST_OK;
                    r_state  <= S_FIN;
                end

                S_FIN: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_status;
                        r_ogrant <= (r_status == falloc_pkg::ST_OK) ? r_grant : '0;
                        r_oavail <= r_avail;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes must arrive only while idle; the block does not enforce it
            if (c_cfg_wr) begin
                if (paddr[2] == falloc_pkg::REG_POLICY) begin
                    r_policy <= pwdata[1:0];
                end else begin
                    r_pool  <= pwdata[AW-1:0];
                    r_avail <= pwdata[AW-1:0];
                    r_fs[0] <= '0;
                    r_fl[0] <= pwdata[AW-1:0];
                    r_fcnt  <= (pwdata[AW-1:0] != '0) ? CW'(1) : '0;
                    r_ucnt  <= '0;
                end
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == falloc_pkg::REG_POLICY) ?
                    {{(falloc_pkg::DW-2){1'b0}}, r_policy} :
                    {{(falloc_pkg::DW-AW){1'b0}}, r_pool};

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_ostat;
    assign o_rsp.granted_address = r_ogrant;
    assign o_rsp.available_bytes = r_oavail;

    `FA_ASSERT(a_fcnt_max, r_fcnt <= CW'(falloc_pkg::FN), "free count overflow")
    `FA_ASSERT(a_ucnt_max, r_ucnt <= UCW'(falloc_pkg::BN), "used count overflow")
    `FA_ASSERT_NEXT(a_busy_after_acc, c_req_acc, r_state != S_IDLE,
        "sequencer idle right after accepting an item")
    `FA_ASSERT_NEXT(a_fin_loads, r_state == S_FIN && (!r_ovalid || o_rsp.ready),
        r_ovalid && r_state == S_IDLE, "finished item not loaded into output")
endmodule

FILE: bench/alloc_checker.sv
// Checker for the free-list allocator: mirrors the free and used tables,
// predicts each response and compares it. Depends on falloc_pkg and falloc_if.
module alloc_checker
    import falloc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    falloc_req_if          req,
    falloc_rsp_if          rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [PAW-1:0] paddr,
    input  logic [DW-1:0]  pwdata,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] granted;
        logic [AW-1:0] avail;
    } t_rsp;

    t_rsp        rsp_due_q[$];
    logic [1:0]  policy;
    int unsigned pool;
    int unsigned fst[FN+1], fln[FN+1], fcnt;
    int unsigned ust[BN], uln[BN], ucnt;

    function automatic void tables_init();
        for (int i = 0; i <= FN; i++) begin
            fst[i] = 0;
            fln[i] = 0;
        end
        ucnt = 0;
        fcnt = (pool != 0) ? 1 : 0;
        fln[0] = pool;
    endfunction

    function automatic int unsigned free_total();
        int unsigned s;
        s = 0;
        for (int i = 0; i < fcnt; i++) s += fln[i];
        return s & 16'hFFFF;
    endfunction

    function automatic logic [1:0] carve(int unsigned size, output int unsigned g);
        int  pick;
        bit  found;
        pick = 0;
        found = 0;
        g = 0;
        if (size == 0) return ST_NOFIT;
        for (int i = 0; i < fcnt; i++) begin
            if (fln[i] < size) continue;
            if (!found) begin
                pick = i;
                found = 1;
                if (policy != FIT_BEST && policy != FIT_WORST) break;
            end else if (policy == FIT_BEST && fln[i] < fln[pick]) begin
                pick = i;
            end else if (policy == FIT_WORST && fln[i] > fln[pick]) begin
                pick = i;
            end
        end
        if (!found) return ST_NOFIT;
        if (ucnt >= BN) return ST_FULL;
        ust[ucnt] = fst[pick];
        uln[ucnt] = size;
        ucnt++;
        g = fst[pick];
        if (fln[pick] == size) begin
            for (int i = pick; i + 1 < fcnt; i++) begin
                fst[i] = fst[i+1];
                fln[i] = fln[i+1];
            end
            fcnt--;
        end else begin
            fst[pick] = (fst[pick] + size) & 16'hFFFF;
            fln[pick] -= size;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] give_back(int unsigned addr);
        int unsigned ts[FN+1], tl[FN+1];
        int  n, u, pos, i;
        bit  hit;
        hit = 0;
        n = fcnt;
        for (u = 0; u < ucnt; u++) begin
            if (ust[u] == addr) begin
                hit = 1;
                break;
            end
        end
        if (!hit) return ST_UNKNOWN;
        pos = 0;
        while (pos < n && fst[pos] < addr) pos++;
        for (i = 0; i < pos; i++) begin
            ts[i] = fst[i];
            tl[i] = fln[i];
        end
        ts[pos] = addr;
        tl[pos] = uln[u];
        for (i = pos; i < n; i++) begin
            ts[i+1] = fst[i];
            tl[i+1] = fln[i];
        end
        n++;
        // merge until no neighbors touch
        i = 0;
        while (i + 1 < n) begin
            if (ts[i] + tl[i] == ts[i+1]) begin
                tl[i] += tl[i+1];
                for (int k = i + 1; k + 1 < n; k++) begin
                    ts[k] = ts[k+1];
                    tl[k] = tl[k+1];
                end
                n--;
            end else begin
                i++;
            end
        end
        if (n > FN) return ST_FULL;
        for (i = 0; i < n; i++) begin
            fst[i] = ts[i];
            fln[i] = tl[i];
        end
        fcnt = n;
        for (i = u; i + 1 < ucnt; i++) begin
            ust[i] = ust[i+1];
            uln[i] = uln[i+1];
        end
        ucnt--;
        return ST_OK;
    endfunction

    assign pending = rsp_due_q.size();

    always @(posedge i_clk) begin
        t_rsp        want, got;
        int unsigned g;
        if (!i_rst_n) begin
            policy = FIT_FIRST;
            pool = 32'(POOL_RST);
            tables_init();
            rsp_due_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[PAW-1:2] == REG_POLICY) begin
                    policy = pwdata[1:0];
                end else if (paddr[PAW-1:2] == REG_POOL) begin
                    pool = 32'(pwdata[AW-1:0]);
                    tables_init();
                end
            end
            if (req.valid && req.ready) begin
                g = 0;
                if (req.opcode == OP_ALLOC)
                    want.status = carve(32'(req.request_size), g);
                else
                    want.status = give_back(32'(req.block_address));
                if (want.status != ST_OK) g = 0;
                want.granted = g[AW-1:0];
                want.avail = AW'(free_total());
                rsp_due_q.push_back(want);
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.granted_address, rsp.available_bytes};
                if (rsp_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected response %p", got);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch (expected/actual): status %0d/%0d addr %0d/%0d free %0d/%0d",
                                     want.status, got.status, want.granted, got.granted,
                                     want.avail, got.avail);
                    end
                end
            end
        end
    end
endmodule

FILE: bench/testbench.sv
// Top of the allocator bench: clock, reset, APB writes, request stimulus
// and verdict. Depends on falloc_pkg, falloc_if, alloc_checker and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import falloc_pkg::*;

    logic           i_clk, i_rst_n;
    logic           psel, penable, pwrite, pready;
    logic [PAW-1:0] paddr;
    logic [DW-1:0]  pwdata, prdata;
    int             errors, pending;
    int             src_idle, snk_stall;   // percent per cycle
    int unsigned    cur_pool;
    int             n_items;
    logic [AW-1:0]  live_q[$];             // addresses believed allocated
    logic           sent_op_q[$];          // opcode of each item in flight

    falloc_req_if req_ch();
    falloc_rsp_if rsp_ch();

    fit_policy_free_list_allocator_unit dut (
        .i_clk  (i_clk),   .i_rst_n (i_rst_n),
        .i_req  (req_ch),  .o_rsp   (rsp_ch),
        .psel   (psel),    .penable (penable), .pwrite (pwrite),
        .paddr  (paddr),   .pwdata  (pwdata),  .prdata (prdata),
        .pready (pready)
    );

    alloc_checker chk (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .req (req_ch), .rsp (rsp_ch),
        .psel (psel), .penable (penable), .pwrite (pwrite), .pready (pready),
        .paddr (paddr), .pwdata (pwdata), .errors (errors), .pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("** fit_policy_free_list_allocator_unit: FAILED **");
        $finish;
    end

    // Response side: random back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall);
    end

    // Track granted blocks so most releases hit a live block.
    always @(posedge i_clk) begin
        if (req_ch.valid && req_ch.ready) sent_op_q.push_back(req_ch.opcode);
        if (rsp_ch.valid && rsp_ch.ready && sent_op_q.size() > 0) begin
            if (sent_op_q.pop_front() == OP_ALLOC && rsp_ch.status == ST_OK)
                live_q.push_back(rsp_ch.granted_address);
        end
    end

    // One item: random idle gap, then hold valid until accepted.
    task automatic send(logic op, logic [AW-1:0] size, logic [AW-1:0] addr);
        while ($urandom_range(0, 99) < src_idle) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.opcode = op;
        req_ch.request_size = size;
        req_ch.block_address = addr;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        n_items++;
    endtask

    // Register write only once the block has drained.
    task automatic reg_write(logic idx, logic [DW-1:0] val);
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);   // let a finished item leave the sequencer
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (idx == REG_POOL) begin
            cur_pool = 32'(val[AW-1:0]);
            live_q.delete();
        end
    endtask

    task automatic release_live(int pick);
        logic [AW-1:0] a;
        a = live_q[pick];
        live_q.delete(pick);
        send(OP_RELEASE, AW'($urandom), a);
    endtask

    initial begin
        int r, pick;
        logic [AW-1:0] sz;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.opcode = OP_ALLOC;
        req_ch.request_size = '0; req_ch.block_address = '0;
        src_idle = 0; snk_stall = 0; cur_pool = 32'(POOL_RST); n_items = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: whole-pool grab, no fit, its release, zero size, unknown block.
        send(OP_ALLOC, 16'hFFFF, '0);
        send(OP_ALLOC, 16'd1, '0);
        send(OP_RELEASE, '0, '0);
        send(OP_ALLOC, 16'd0, 16'hFFFF);
        send(OP_RELEASE, 16'hFFFF, 16'hFFFF);
        // Best fit on a fragmented pool, then worst fit.
        reg_write(REG_POLICY, DW'(FIT_BEST));
        reg_write(REG_POOL, 40);
        for (int i = 0; i < 4; i++) send(OP_ALLOC, 16'd4, '0);
        send(OP_RELEASE, '0, 16'd4);
        send(OP_ALLOC, 16'd3, '0);
        reg_write(REG_POLICY, DW'(FIT_WORST));
        send(OP_RELEASE, '0, 16'd0);
        send(OP_ALLOC, 16'd2, '0);
        // Used table full; unused policy code; empty and one-byte pools.
        reg_write(REG_POLICY, 32'd3);
        reg_write(REG_POOL, 20);
        for (int i = 0; i < BN + 1; i++) send(OP_ALLOC, 16'd1, '0);
        reg_write(REG_POOL, 0);
        send(OP_ALLOC, 16'd1, '0);
        reg_write(REG_POOL, 1);
        send(OP_ALLOC, 16'd1, '0);
        send(OP_RELEASE, '0, 16'd0);

        // Random: four idling phases, each with its own policy code and a new pool.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 28) : 0;
            snk_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 28) : 0;
            reg_write(REG_POLICY, ph);
            reg_write(REG_POOL, (ph == 0) ? 65535 : $urandom_range(48, 400));
            for (int k = 0; k < 125; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    if ($urandom_range(0, 19) == 0) sz = AW'($urandom);
                    else sz = AW'($urandom_range(1, cur_pool / 10 + 1));
                    send(OP_ALLOC, sz, AW'($urandom));
                end else if (r < 93 && live_q.size() > 0) begin
                    pick = $urandom_range(0, live_q.size() - 1);
                    release_live(pick);
                end else begin
                    send(OP_RELEASE, AW'($urandom), AW'($urandom));
                end
            end
        end

        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Ran %0d items: all fit policies, pools 0 to 65535, four idling mixes.",
                 n_items);
        $display("Mismatches: %0d", errors);
        if (errors == 0) begin
            $display("** fit_policy_free_list_allocator_unit: PASSED **");
        end else begin
            $display("** fit_policy_free_list_allocator_unit: FAILED **");
        end
        $finish;
    end
endmodule

FILE: fit_policy_free_list_allocator_unit.f
+incdir+rtl
rtl/falloc_pkg.sv
rtl/falloc_if.sv
rtl/falloc_alu.sv
rtl/fit_policy_free_list_allocator_unit.sv
bench/alloc_checker.sv
bench/testbench.sv
